// File: rtl/core/ptc_pkg.sv
package ptc_pkg;

	localparam int unsigned CMD_BITS    = 2;
	localparam int unsigned LEVEL_BITS  = 12;
	localparam int unsigned PRE_BITS    = 11;
	localparam int unsigned INDEX_BITS  = 11;
	localparam int unsigned VALUE_BITS  = 12;
	localparam int unsigned PHASE_BITS  = 2;
	localparam int unsigned CFG_BITS    = 12;
	localparam int unsigned CFG_IDX_BITS = 1;

	localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_ARM    = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_TRIGGER_LEVEL    = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PRETRIGGER_COUNT = 1'b1;

	localparam logic [LEVEL_BITS-1:0] TRIGGER_LEVEL_RESET    = 12'd1200;
	localparam logic [PRE_BITS-1:0]   PRETRIGGER_COUNT_RESET = 11'd200;

	typedef enum logic [3:0] {
		PH_RUNNING   = 4'b0001,
		PH_ARMED     = 4'b0010,
		PH_TRIGGERED = 4'b0100,
		PH_STOPPED   = 4'b1000
	} phase_t;

	localparam logic [PHASE_BITS-1:0] CODE_RUNNING   = 2'd0;
	localparam logic [PHASE_BITS-1:0] CODE_ARMED     = 2'd1;
	localparam logic [PHASE_BITS-1:0] CODE_TRIGGERED = 2'd2;
	localparam logic [PHASE_BITS-1:0] CODE_STOPPED   = 2'd3;

	typedef struct packed {
		logic                  done;
		logic [INDEX_BITS-1:0] start_index;
		logic [PHASE_BITS-1:0] phase;
		logic                  is_read;
	} res_t;

	function automatic logic [PHASE_BITS-1:0] phase_code(input phase_t ph);
		logic [PHASE_BITS-1:0] code;
		unique case (ph)
			PH_RUNNING:   code = CODE_RUNNING;
			PH_ARMED:     code = CODE_ARMED;
			PH_TRIGGERED: code = CODE_TRIGGERED;
			PH_STOPPED:   code = CODE_STOPPED;
			default:      code = CODE_RUNNING;
		endcase
		return code;
	endfunction

endpackage

// File: rtl/core/ptc_ram.sv
module ptc_ram #(
	parameter int unsigned WIDTH = 12,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/ptc_ctrl.sv
module ptc_ctrl #(
	parameter int unsigned DEPTH       = 2048,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ptc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [ptc_pkg::CFG_BITS-1:0]         cfg_data,
	input  logic                                 step,
	input  logic [ptc_pkg::CMD_BITS-1:0]         cmd,
	input  logic [ptc_pkg::VALUE_BITS-1:0]       sample,
	input  logic [ptc_pkg::INDEX_BITS-1:0]       read_addr,
	output logic                                 ram_we,
	output logic [$clog2(DEPTH)-1:0]             ram_waddr,
	output logic [SAMPLE_BITS-1:0]               ram_wdata,
	output logic                                 ram_re,
	output logic [$clog2(DEPTH)-1:0]             ram_raddr,
	output ptc_pkg::res_t                        res
);

	import ptc_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic [LEVEL_BITS-1:0] level_q;
	logic [PRE_BITS-1:0]   pre_q;
	logic [AW-1:0]         wpos_q;
	logic [AW-1:0]         start_q;
	phase_t                phase_q;

	logic [SAMPLE_BITS-1:0] smp;
	logic                   is_sample;
	logic                   trig;
	logic [AW-1:0]          pos_inc;
	logic [AW-1:0]          start_n;
	logic [AW-1:0]          wpos_n;
	phase_t                 phase_mid;
	phase_t                 phase_n;
	logic                   done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= TRIGGER_LEVEL_RESET;
			pre_q   <= PRETRIGGER_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRIGGER_LEVEL:    level_q <= cfg_data[LEVEL_BITS-1:0];
				REG_PRETRIGGER_COUNT: pre_q   <= cfg_data[PRE_BITS-1:0];
				default:              level_q <= level_q;
			endcase
		end
	end

	always_comb begin
		smp       = SAMPLE_BITS'(sample);
		is_sample = (cmd == CMD_SAMPLE) && (phase_q != PH_STOPPED);
		// Only armed samples strictly above the level can trigger.
		trig      = is_sample && (phase_q == PH_ARMED) && (16'(smp) > 16'(level_q));
		// The user keeps the store depth a power of two (not checked), so ring arithmetic wraps.
		start_n   = trig ? (wpos_q - AW'(pre_q)) : start_q;
		pos_inc   = wpos_q + AW'(1);
		wpos_n    = is_sample ? pos_inc : wpos_q;
		phase_mid = trig ? PH_TRIGGERED : phase_q;
		done      = is_sample && (phase_mid == PH_TRIGGERED) && (pos_inc == start_n);
		if (is_sample) begin
			phase_n = done ? PH_STOPPED : phase_mid;
		end else if (cmd == CMD_ARM) begin
			phase_n = PH_ARMED;
		end else begin
			phase_n = phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q  <= '0;
			start_q <= '0;
			phase_q <= PH_RUNNING;
		end else if (step) begin
			wpos_q  <= wpos_n;
			start_q <= start_n;
			phase_q <= phase_n;
		end
	end

	assign ram_we    = step && is_sample;
	assign ram_waddr = wpos_q;
	assign ram_wdata = smp;
	assign ram_re    = step && (cmd == CMD_READ);
	assign ram_raddr = AW'(read_addr);

	assign res.done        = done;
	assign res.start_index = INDEX_BITS'(start_n);
	assign res.phase       = phase_code(phase_n);
	assign res.is_read     = (cmd == CMD_READ);

	a_wpos_advance: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_sample |=> wpos_q == AW'($past(wpos_q) + AW'(1)))
		else $error("write position did not advance on a stored sample");

	a_stopped_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && (phase_q == PH_STOPPED) && (cmd != CMD_ARM) |=> $stable(wpos_q)
			&& phase_q == PH_STOPPED)
		else $error("stopped capture moved without an arm");

	a_done_closes_ring: assert property (@(posedge clk) disable iff (!arst_n)
		step && done |=> (phase_q == PH_STOPPED) && (wpos_q == start_q))
		else $error("capture completed away from its start position");

	a_start_only_on_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		step && !trig |=> $stable(start_q))
		else $error("capture start moved without a trigger");

endmodule

// File: rtl/core/ptc_pipe.sv
module ptc_pipe #(
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	output logic                             accept,
	input  ptc_pkg::res_t                    res,
	input  logic [SAMPLE_BITS-1:0]           rd_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             capture_done,
	output logic [ptc_pkg::INDEX_BITS-1:0]   start_index,
	output logic [ptc_pkg::VALUE_BITS-1:0]   read_value,
	output logic [ptc_pkg::PHASE_BITS-1:0]   phase_now
);

	import ptc_pkg::*;

	logic valid_s1;
	res_t res_s1;
	logic s1_adv;

	// Stage 1 waits for the store's registered read data; the output register
	// then holds the beat until the receiver takes it.
	assign s1_adv   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			capture_done <= res_s1.done;
			start_index  <= res_s1.start_index;
			phase_now    <= res_s1.phase;
			read_value   <= res_s1.is_read ? VALUE_BITS'(rd_data) : '0;
		end
	end

endmodule

// File: rtl/core/pretrigger_capture_top.sv
// Pretrigger ring capture, oscilloscope style.
// Input beats carry cmd, sample and read_addr under in_valid/in_stall; every
// accepted beat yields exactly one result beat under out_valid/out_stall.
// A sample command writes the ring and advances the write position; an arm
// command enables the trigger; a read command returns the stored sample.
// The first armed sample above trigger_level fixes the capture start, and the
// beat whose write closes the ring reports capture_done with start_index.
// Throughput is one beat per clock while the receiver does not stall: the store
// takes one write or one read per beat on its single port, and the next-state
// logic is combinational. A beat passes through the read stage, which waits for
// the store's registered read data, and then the output register, which holds
// the result under out_valid.
// When the receiver stalls, the output register holds its beat, one more beat
// waits in the read stage, and in_stall rises after that.
// Reset clears the write position, the capture start and the phase (running)
// and loads the register defaults; store contents are not cleared.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and
// must only be made while no beat is in flight.
// DEPTH must be a power of two.
module pretrigger_capture_top #(
	parameter int unsigned DEPTH       = 2048,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ptc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [ptc_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ptc_pkg::CMD_BITS-1:0]       cmd,
	input  logic [ptc_pkg::VALUE_BITS-1:0]     sample,
	input  logic [ptc_pkg::INDEX_BITS-1:0]     read_addr,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               capture_done,
	output logic [ptc_pkg::INDEX_BITS-1:0]     start_index,
	output logic [ptc_pkg::VALUE_BITS-1:0]     read_value,
	output logic [ptc_pkg::PHASE_BITS-1:0]     phase_now
);

	import ptc_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic                   accept;
	res_t                   res;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [SAMPLE_BITS-1:0] ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	ptc_ctrl #(
		.DEPTH       (DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (accept),
		.cmd       (cmd),
		.sample    (sample),
		.read_addr (read_addr),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.res       (res)
	);

	ptc_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ptc_pipe #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.accept       (accept),
		.res          (res),
		.rd_data      (ram_rdata),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.capture_done (capture_done),
		.start_index  (start_index),
		.read_value   (read_value),
		.phase_now    (phase_now)
	);

endmodule
